// ===== hdl/dbdc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbdc_pkg
// Types, codes and helpers shared by the dual beam direction counter.
// ----------------------------------------------------------------------------
package dbdc_pkg;

  // internal time store and counter widths
  localparam int STAMP_BITS = 40;
  localparam int COUNT_BITS = 16;

  // fixed widths of the stream fields and registers
  localparam int STAMP_FIELD_BITS = 40;
  localparam int TOTAL_BITS       = 16;
  localparam int CFG_BITS         = 26;
  localparam int CFG_INDEX_BITS   = 8;
  localparam int CMP_BITS         = (STAMP_BITS > CFG_BITS) ? STAMP_BITS : CFG_BITS;

  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(1000000);
  localparam logic [CFG_BITS-1:0] SKEW_RESET   = CFG_BITS'(1000000);

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_WINDOW = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAIR_SKEW   = CFG_INDEX_BITS'(1);

  // item kinds, beams and levels
  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_REPORT = 1'b1;
  localparam logic BEAM_ENTRY  = 1'b0;
  localparam logic BEAM_EXIT   = 1'b1;
  localparam logic LEVEL_FALL  = 1'b0;
  localparam logic LEVEL_RISE  = 1'b1;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;

  typedef enum logic [1:0] {
    CROSS_NONE  = 2'd0,
    CROSS_ENTRY = 2'd1,
    CROSS_EXIT  = 2'd2,
    CROSS_BOTH  = 2'd3
  } crossing_t;

  // time store and counters
  typedef struct packed {
    logic [1:0][STAMP_BITS-1:0] fall_now;
    logic [1:0][STAMP_BITS-1:0] rise_now;
    logic [1:0][STAMP_BITS-1:0] fall_prev;
    logic [1:0][STAMP_BITS-1:0] rise_prev;
    logic [1:0]                 seen;
    count_t                     entries;
    count_t                     exits;
  } dbdc_state_t;

  typedef struct packed {
    crossing_t               crossing;
    logic [TOTAL_BITS-1:0]   exit_total;
    logic [TOTAL_BITS-1:0]   entry_total;
  } dbdc_result_t;

  function automatic stamp_t stamp_from_field(logic [STAMP_FIELD_BITS-1:0] f);
    logic [STAMP_FIELD_BITS+STAMP_BITS-1:0] wide;
    wide = {{STAMP_BITS{1'b0}}, f};
    return wide[STAMP_BITS-1:0];
  endfunction

  function automatic logic [TOTAL_BITS-1:0] count_to_total(count_t c);
    logic [TOTAL_BITS+COUNT_BITS-1:0] wide;
    wide = {{TOTAL_BITS{1'b0}}, c};
    return wide[TOTAL_BITS-1:0];
  endfunction

  function automatic cmp_t stamp_to_cmp(stamp_t s);
    logic [CMP_BITS+STAMP_BITS-1:0] wide;
    wide = {{CMP_BITS{1'b0}}, s};
    return wide[CMP_BITS-1:0];
  endfunction

  function automatic cmp_t cfg_to_cmp(logic [CFG_BITS-1:0] v);
    logic [CMP_BITS+CFG_BITS-1:0] wide;
    wide = {{CMP_BITS{1'b0}}, v};
    return wide[CMP_BITS-1:0];
  endfunction

  function automatic stamp_t abs_diff(stamp_t a, stamp_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + count_t'(1);
  endfunction

endpackage

// ===== hdl/dbdc_classify.sv =====
// ----------------------------------------------------------------------------
// dbdc_classify
// Next value of the time store and counters, and the result, for one item.
// ----------------------------------------------------------------------------
module dbdc_classify (
  input  dbdc_pkg::dbdc_state_t              state_q,
  input  logic                               mode,
  input  logic                               beam,
  input  logic                               level,
  input  dbdc_pkg::stamp_t                   stamp,
  input  logic [dbdc_pkg::CFG_BITS-1:0]      fall_window,
  input  logic [dbdc_pkg::CFG_BITS-1:0]      pair_skew,
  output dbdc_pkg::dbdc_state_t              state_d,
  output dbdc_pkg::dbdc_result_t             result
);

  logic             a;
  logic             b;
  dbdc_pkg::stamp_t fn_a;
  dbdc_pkg::stamp_t fn_b;
  dbdc_pkg::stamp_t d1;
  dbdc_pkg::stamp_t d2;
  logic             analyse;
  logic             win_ok;
  logic             pair_ok;
  logic             dir_ok;

  assign a = beam;
  assign b = ~beam;

  assign fn_a = state_q.fall_now[a];
  assign fn_b = state_q.fall_now[b];

  // rise of a: both beams clear again and a rose last
  assign analyse = (stamp > state_q.rise_now[b]) && (state_q.rise_now[b] > fn_b);

  assign win_ok = dbdc_pkg::stamp_to_cmp(dbdc_pkg::abs_diff(fn_a, fn_b))
                  < dbdc_pkg::cfg_to_cmp(fall_window);

  // rise_prev of a becomes the old rise_now of a on this edge
  assign d1 = dbdc_pkg::abs_diff(state_q.fall_prev[a], fn_b);
  assign d2 = dbdc_pkg::abs_diff(stamp, state_q.rise_now[b]);
  assign pair_ok = (state_q.rise_now[a] > fn_b) &&
                   ((d1 <= d2) ||
                    (dbdc_pkg::stamp_to_cmp(d1 - d2) < dbdc_pkg::cfg_to_cmp(pair_skew)));
  assign dir_ok = fn_a > fn_b;

  always_comb begin
    dbdc_pkg::dbdc_state_t st;
    dbdc_pkg::crossing_t   code;
    logic                  roll;
    st   = state_q;
    code = dbdc_pkg::CROSS_NONE;
    roll = 1'b0;
    result.entry_total = dbdc_pkg::count_to_total(state_q.entries);
    result.exit_total  = dbdc_pkg::count_to_total(state_q.exits);
    if (mode == dbdc_pkg::MODE_REPORT) begin
      st.entries = '0;
      st.exits   = '0;
    end else begin
      if (!state_q.seen[a]) begin
        st.seen[a] = 1'b1;
      end else if (level == dbdc_pkg::LEVEL_FALL) begin
        st.fall_prev[a] = state_q.fall_now[a];
        st.fall_now[a]  = stamp;
      end else begin
        st.rise_prev[a] = state_q.rise_now[a];
        st.rise_now[a]  = stamp;
        if (analyse && win_ok) begin
          priority if (pair_ok) begin
            st.entries = dbdc_pkg::sat_inc(state_q.entries);
            st.exits   = dbdc_pkg::sat_inc(state_q.exits);
            code       = dbdc_pkg::CROSS_BOTH;
            roll       = 1'b1;
          end else if (dir_ok) begin
            if (a == dbdc_pkg::BEAM_EXIT) begin
              st.entries = dbdc_pkg::sat_inc(state_q.entries);
              code       = dbdc_pkg::CROSS_ENTRY;
            end else begin
              st.exits = dbdc_pkg::sat_inc(state_q.exits);
              code     = dbdc_pkg::CROSS_EXIT;
            end
            roll = 1'b1;
          end else begin
            code = dbdc_pkg::CROSS_NONE;
          end
        end
      end
      if (roll) begin
        st.fall_prev = st.fall_now;
        st.rise_prev = st.rise_now;
        st.fall_now  = '0;
        st.rise_now  = '0;
      end
      // edges report totals after their own update
      result.entry_total = dbdc_pkg::count_to_total(st.entries);
      result.exit_total  = dbdc_pkg::count_to_total(st.exits);
    end
    result.crossing = code;
    state_d         = st;
  end

endmodule

// ===== hdl/dual_beam_direction_counter_core.sv =====
// Pipeline: an input transaction passes the input register, then the result register;
// the time store updates as the item leaves the input register.
// Throughput: one item per cycle while out_tready is not holding the result register, limited by the time store update.
// Reset (rst_n low, synchronous): time store, counters and first-edge flags clear,
// both stages empty, both window registers return to 1000000 us.
// ----------------------------------------------------------------------------
// dual_beam_direction_counter_core
// Counts entries and exits from timestamped edges of an entry and an exit beam.
// ----------------------------------------------------------------------------
module dual_beam_direction_counter_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [0] level, [40:1] stamp_us, rest zero
  input  logic [1:0]  in_tuser,   // [0] mode, [1] beam

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] entry_total, [31:16] exit_total
  output logic [1:0]  out_tuser,  // [1:0] crossing

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbdc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dbdc_pkg::CFG_BITS-1:0]       cfg_data
);

  logic                           in_valid_r;
  logic                           in_mode_r;
  logic                           in_beam_r;
  logic                           in_level_r;
  dbdc_pkg::stamp_t               in_stamp_r;
  dbdc_pkg::dbdc_state_t          state_r;
  dbdc_pkg::dbdc_state_t          state_nxt;
  dbdc_pkg::dbdc_result_t         res_nxt;
  dbdc_pkg::dbdc_result_t         res_r;
  logic                           out_valid_r;
  logic [dbdc_pkg::CFG_BITS-1:0]  fall_window_r;
  logic [dbdc_pkg::CFG_BITS-1:0]  pair_skew_r;
  logic                           advance;
  logic                           fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.exit_total, res_r.entry_total};
  assign out_tuser  = res_r.crossing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_window_r <= dbdc_pkg::WINDOW_RESET;
      pair_skew_r   <= dbdc_pkg::SKEW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == dbdc_pkg::REG_FALL_WINDOW) begin
        fall_window_r <= cfg_data;
      end
      if (cfg_index == dbdc_pkg::REG_PAIR_SKEW) begin
        pair_skew_r <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r  <= in_tuser[0];
      in_beam_r  <= in_tuser[1];
      in_level_r <= in_tdata[0];
      in_stamp_r <= dbdc_pkg::stamp_from_field(in_tdata[40:1]);
    end
  end

  dbdc_classify u_classify (
    .state_q     (state_r),
    .mode        (in_mode_r),
    .beam        (in_beam_r),
    .level       (in_level_r),
    .stamp       (in_stamp_r),
    .fall_window (fall_window_r),
    .pair_skew   (pair_skew_r),
    .state_d     (state_nxt),
    .result      (res_nxt)
  );

  // time store and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // a stalled item stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_stamp_r))
    else $error("input item lost while result stalled");

  // a report clears both counters
  a_report_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_mode_r == dbdc_pkg::MODE_REPORT |=> state_r.entries == '0 && state_r.exits == '0)
    else $error("counters not cleared by report");

  // a report never carries a crossing
  a_report_code: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_mode_r == dbdc_pkg::MODE_REPORT |=> out_tuser == dbdc_pkg::CROSS_NONE)
    else $error("crossing reported on a report item");

  // edges never decrease the counters
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_mode_r == dbdc_pkg::MODE_EDGE |=>
      state_r.entries >= $past(state_r.entries) && state_r.exits >= $past(state_r.exits))
    else $error("counter decreased on an edge");

  // every counted crossing rolls the store
  a_roll: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.crossing != dbdc_pkg::CROSS_NONE |=>
      state_r.fall_now == '0 && state_r.rise_now == '0)
    else $error("store did not roll after a crossing");

endmodule
